FILE: rtl/button_press_classifier_led_blinker_core_macros.svh
// ----------------------------------------------------------------------------
// Button classifier assertion macros
// Clocked assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_LED_BLINKER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_LED_BLINKER_CORE_MACROS_SVH

// Checked outside reset only.
`define BPLB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bplb assertion failed");

// Checked at every edge, reset included.
`define BPLB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bplb assertion failed");

`endif

FILE: rtl/bplb_pkg.sv
// ----------------------------------------------------------------------------
// Button classifier package
// Codes, register layout and shared types of the button classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bplb_pkg;

  // Item kinds
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // LED commands
  localparam logic [3:0] CMD_PWR_ON        = 4'd0;
  localparam logic [3:0] CMD_PWR_OFF       = 4'd1;
  localparam logic [3:0] CMD_STA_ON        = 4'd2;
  localparam logic [3:0] CMD_STA_OFF       = 4'd3;
  localparam logic [3:0] CMD_STA_BLINK_ON  = 4'd4;
  localparam logic [3:0] CMD_STA_BLINK_OFF = 4'd5;
  localparam logic [3:0] CMD_PWR_BLINK_ON  = 4'd6;
  localparam logic [3:0] CMD_PWR_BLINK_OFF = 4'd7;

  // Latched events
  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_SHORT = 2'd1;
  localparam logic [1:0] EVT_LONG  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
  localparam logic [1:0] REG_SHORT_LIMIT = 2'd1;
  localparam logic [1:0] REG_BLINK_DIV   = 2'd2;

  localparam logic [5:0] LONG_PRESS_RST  = 6'd50;
  localparam logic [5:0] SHORT_LIMIT_RST = 6'd15;
  localparam logic [2:0] BLINK_DIV_RST   = 3'd5;

  localparam logic [5:0] PRESS_MAX = 6'd63;

  typedef struct packed {
    logic [5:0] long_press_ticks;
    logic [5:0] short_press_limit;
    logic [2:0] power_blink_divisor;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bplb_cfg.sv
// ----------------------------------------------------------------------------
// Button classifier register file
// APB-style access to the press thresholds and the power blink divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bplb_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output bplb_pkg::cfg_t      cfg
);
  import bplb_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks    <= LONG_PRESS_RST;
      cfg.short_press_limit   <= SHORT_LIMIT_RST;
      cfg.power_blink_divisor <= BLINK_DIV_RST;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_PRESS:  cfg.long_press_ticks    <= pwdata[5:0];
        REG_SHORT_LIMIT: cfg.short_press_limit   <= pwdata[5:0];
        REG_BLINK_DIV:   cfg.power_blink_divisor <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:  prdata = {26'd0, cfg.long_press_ticks};
      REG_SHORT_LIMIT: prdata = {26'd0, cfg.short_press_limit};
      REG_BLINK_DIV:   prdata = {29'd0, cfg.power_blink_divisor};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/button_press_classifier_led_blinker_core.sv
// ----------------------------------------------------------------------------
// Button press classifier and LED blinker
// Classifies button presses from sampled ticks and drives two blinking LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item: tuser selects tick, LED command or
//   event read; tdata holds the button sample and the command code.
//   m_* returns exactly one result per request: LED drives, the event code
//   of a read, the pending flag and the command error flag.
//   The result of a request accepted at one edge is valid from that edge
//   on. Throughput is one request per cycle when not stalled, set by the
//   single result register; state is updated in the accepting cycle.
//   When the receiver stalls the result register holds and s_tready drops
//   until the result is taken; a taken result frees room the same cycle.
//   Reset clears the press tracker, LEDs, blink enables and the latched
//   event, loads the register defaults (50, 15, 5) and empties the output.
//   Registers sit on the APB-style port at byte offsets 0, 4 and 8; the user
//   must write them only while no request is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_led_blinker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // button_pressed[0], command[4:1], zero
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // status_led[0], power_led[1],
                                      // event_code[3:2], event_pending[4],
                                      // command_error[5], zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import bplb_pkg::*;

  cfg_t cfg;

  logic       accept;
  logic [1:0] op;
  logic       pressed;
  logic [3:0] cmd;

  logic       in_press,      in_press_next;
  logic [5:0] press_ticks,   press_ticks_next;
  logic       long_reported, long_reported_next;
  logic [2:0] blink_phase,   blink_phase_next;
  logic       sta_led,       sta_led_next;
  logic       pwr_led,       pwr_led_next;
  logic       sta_blink,     sta_blink_next;
  logic       pwr_blink,     pwr_blink_next;
  logic [1:0] latched_event, latched_event_next;
  logic [1:0] code;
  logic       err;
  logic [2:0] phase_a;
  logic [5:0] ticks_a;
  logic       long_a;

  function automatic logic [2:0] phase_step(input logic [2:0] ph, input logic [2:0] div);
    logic [2:0] n;
    n = ph + 3'd1;
    if (n >= div) n = 3'd0;
    return n;
  endfunction

  bplb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser;
  assign pressed  = s_tdata[0];
  assign cmd      = s_tdata[4:1];

  assign phase_a = phase_step(blink_phase, cfg.power_blink_divisor);
  assign ticks_a = !in_press ? 6'd1 :
                   (press_ticks != PRESS_MAX) ? press_ticks + 6'd1 : press_ticks;
  assign long_a  = in_press ? long_reported : 1'b0;

  always_comb begin
    in_press_next      = in_press;
    press_ticks_next   = press_ticks;
    long_reported_next = long_reported;
    blink_phase_next   = blink_phase;
    sta_led_next       = sta_led;
    pwr_led_next       = pwr_led;
    sta_blink_next     = sta_blink;
    pwr_blink_next     = pwr_blink;
    latched_event_next = latched_event;
    code               = EVT_NONE;
    err                = 1'b0;
    case (op)
      OP_TICK: begin
        blink_phase_next = phase_a;
        if (sta_blink) sta_led_next = ~sta_led;
        if (pwr_blink && phase_a == 3'd0) pwr_led_next = ~pwr_led;
        if (pressed) begin
          in_press_next      = 1'b1;
          press_ticks_next   = ticks_a;
          long_reported_next = long_a;
          if (ticks_a > cfg.long_press_ticks && !long_a) begin
            long_reported_next = 1'b1;
            latched_event_next = EVT_LONG;
            // extra phase step on a long press, no LED toggle
            blink_phase_next   = phase_step(phase_a, cfg.power_blink_divisor);
          end
        end else if (in_press) begin
          if (press_ticks < cfg.short_press_limit) latched_event_next = EVT_SHORT;
          in_press_next      = 1'b0;
          press_ticks_next   = 6'd0;
          long_reported_next = 1'b0;
        end
      end
      OP_CMD: begin
        case (cmd)
          CMD_PWR_ON:        pwr_led_next = 1'b1;
          CMD_PWR_OFF:       pwr_led_next = 1'b0;
          CMD_STA_ON:        sta_led_next = 1'b1;
          CMD_STA_OFF:       sta_led_next = 1'b0;
          CMD_STA_BLINK_ON:  sta_blink_next = 1'b1;
          CMD_STA_BLINK_OFF: begin
            sta_blink_next = 1'b0;
            sta_led_next   = 1'b0;
          end
          CMD_PWR_BLINK_ON:  pwr_blink_next = 1'b1;
          CMD_PWR_BLINK_OFF: begin
            pwr_blink_next = 1'b0;
            pwr_led_next   = 1'b0;
          end
          default:           err = 1'b1;
        endcase
      end
      OP_READ: begin
        code               = latched_event;
        latched_event_next = EVT_NONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_press      <= 1'b0;
      press_ticks   <= 6'd0;
      long_reported <= 1'b0;
      blink_phase   <= 3'd0;
      sta_led       <= 1'b0;
      pwr_led       <= 1'b0;
      sta_blink     <= 1'b0;
      pwr_blink     <= 1'b0;
      latched_event <= EVT_NONE;
    end else if (accept) begin
      in_press      <= in_press_next;
      press_ticks   <= press_ticks_next;
      long_reported <= long_reported_next;
      blink_phase   <= blink_phase_next;
      sta_led       <= sta_led_next;
      pwr_led       <= pwr_led_next;
      sta_blink     <= sta_blink_next;
      pwr_blink     <= pwr_blink_next;
      latched_event <= latched_event_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, err, (latched_event_next != EVT_NONE), code,
                  pwr_led_next, sta_led_next};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bplb_checker.sv
// ----------------------------------------------------------------------------
// Button classifier port checker
// Watches the top-level streams and flags illegal result behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_led_blinker_core_macros.svh"

module bplb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  `BPLB_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid)

  `BPLB_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  `BPLB_ASSERT(a_req_gives_result, s_tvalid && s_tready |=> m_tvalid)

  // a returned event is cleared by the same read
  `BPLB_ASSERT(a_read_clears, m_tvalid && m_tdata[3:2] != 2'd0 |-> !m_tdata[4] && !m_tdata[5])

  `BPLB_ASSERT(a_event_code, m_tvalid |-> m_tdata[3:2] != 2'd3 && m_tdata[7:6] == 2'd0)

endmodule

bind button_press_classifier_led_blinker_core bplb_checker u_bplb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/led_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button classifier result checker
// Watches the request, result and register channels of the button classifier.
// It keeps its own copy of the press tracker, blink state and registers.
// It predicts one result per accepted request and compares each returned
// result, field by field, with the oldest prediction still due.
// ----------------------------------------------------------------------------

module led_event_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // button_pressed[0], command[4:1], zero
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,   // status_led[0], power_led[1],
                                      // event_code[3:2], event_pending[4],
                                      // command_error[5], zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatches,
  output int               outstanding
);

  import bplb_pkg::*;

  typedef struct packed {
    logic       cmd_err;
    logic       pending;
    logic [1:0] evt;
    logic       power;
    logic       status;
  } led_result_t;

  cfg_t        regs;
  logic        in_press;
  logic [5:0]  press_cnt;
  logic        long_seen;
  logic [2:0]  phase;
  logic        sta_led;
  logic        pwr_led;
  logic        sta_blink;
  logic        pwr_blink;
  logic [1:0]  held_evt;
  led_result_t results_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [2:0] step_phase(input logic [2:0] ph, input logic [2:0] div);
    logic [2:0] nxt;
    nxt = ph + 3'd1;
    if (nxt >= div) begin
      nxt = 3'd0;
    end
    return nxt;
  endfunction

  task automatic classify_and_blink(input logic [1:0] op, input logic pressed,
                                    input logic [3:0] cmd);
    led_result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        phase = step_phase(phase, regs.power_blink_divisor);
        if (sta_blink) begin
          sta_led = ~sta_led;
        end
        if (pwr_blink && phase == 3'd0) begin
          pwr_led = ~pwr_led;
        end
        if (pressed) begin
          if (!in_press) begin
            in_press  = 1'b1;
            press_cnt = 6'd1;
            long_seen = 1'b0;
          end else if (press_cnt < PRESS_MAX) begin
            press_cnt = press_cnt + 6'd1;
          end
          // long press: latch once, and one extra phase step with no blink
          if (press_cnt > regs.long_press_ticks && !long_seen) begin
            long_seen = 1'b1;
            held_evt  = EVT_LONG;
            phase     = step_phase(phase, regs.power_blink_divisor);
          end
        end else if (in_press) begin
          if (press_cnt < regs.short_press_limit) begin
            held_evt = EVT_SHORT;
          end
          in_press  = 1'b0;
          press_cnt = 6'd0;
          long_seen = 1'b0;
        end
      end
      OP_CMD: begin
        case (cmd)
          CMD_PWR_ON:        pwr_led = 1'b1;
          CMD_PWR_OFF:       pwr_led = 1'b0;
          CMD_STA_ON:        sta_led = 1'b1;
          CMD_STA_OFF:       sta_led = 1'b0;
          CMD_STA_BLINK_ON:  sta_blink = 1'b1;
          CMD_STA_BLINK_OFF: begin
            sta_blink = 1'b0;
            sta_led   = 1'b0;
          end
          CMD_PWR_BLINK_ON:  pwr_blink = 1'b1;
          CMD_PWR_BLINK_OFF: begin
            pwr_blink = 1'b0;
            pwr_led   = 1'b0;
          end
          default:           r.cmd_err = 1'b1;
        endcase
      end
      OP_READ: begin
        r.evt    = held_evt;
        held_evt = EVT_NONE;
      end
      default: ;
    endcase
    r.status  = sta_led;
    r.power   = pwr_led;
    r.pending = (held_evt != EVT_NONE);
    results_due.push_back(r);
  endtask

  always @(posedge clk) begin
    led_result_t want;
    led_result_t got;
    if (rst) begin
      regs.long_press_ticks    = LONG_PRESS_RST;
      regs.short_press_limit   = SHORT_LIMIT_RST;
      regs.power_blink_divisor = BLINK_DIV_RST;
      in_press  = 1'b0;
      press_cnt = 6'd0;
      long_seen = 1'b0;
      phase     = 3'd0;
      sta_led   = 1'b0;
      pwr_led   = 1'b0;
      sta_blink = 1'b0;
      pwr_blink = 1'b0;
      held_evt  = EVT_NONE;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[5:0];
        if (results_due.size() == 0) begin
          $error("result with no request pending: tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $error("status_led: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.power !== want.power) begin
            $error("power_led: expected %0d, got %0d", want.power, got.power);
            mismatches++;
          end
          if (got.evt !== want.evt) begin
            $error("event_code: expected %0d, got %0d", want.evt, got.evt);
            mismatches++;
          end
          if (got.pending !== want.pending) begin
            $error("event_pending: expected %0d, got %0d", want.pending, got.pending);
            mismatches++;
          end
          if (got.cmd_err !== want.cmd_err) begin
            $error("command_error: expected %0d, got %0d", want.cmd_err, got.cmd_err);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        classify_and_blink(s_tuser, s_tdata[0], s_tdata[4:1]);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LONG_PRESS:  regs.long_press_ticks    = pwdata[5:0];
          REG_SHORT_LIMIT: regs.short_press_limit   = pwdata[5:0];
          REG_BLINK_DIV:   regs.power_blink_divisor = pwdata[2:0];
          default: ;
        endcase
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button classifier testbench
// Drives ticks, LED commands and event reads into the button classifier with
// bursty requests and a stalling receiver, rewrites the three registers
// between phases, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------

module tb_top;

  import bplb_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // button_pressed[0], command[4:1], zero
  logic [1:0]  s_tuser;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // status_led[0], power_led[1], event_code[3:2],
                          // event_pending[4], command_error[5], zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int idle_cycles;
  int burst_left;
  int items_sent;
  int cur_long;
  int cur_short;

  button_press_classifier_led_blinker_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  led_event_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: periodically picks one of four stall patterns at random
  always @(negedge clk) begin
    int rx_cycle;
    int rx_mode;
    if (rx_cycle % 80 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rx_cycle % 6) >= 4;
      default: m_tready <= (rx_cycle % 3) != 0;
    endcase
    rx_cycle++;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // entered and left at a falling edge
  task automatic push_request(input logic [1:0] op, input logic pressed,
                              input logic [3:0] cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, cmd, pressed};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [5:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {26'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(input int long_v, input int short_v, input int div_v);
    wait_drained();
    apb_write(REG_LONG_PRESS, long_v[5:0]);
    apb_write(REG_SHORT_LIMIT, short_v[5:0]);
    apb_write(REG_BLINK_DIV, {3'b000, div_v[2:0]});
    cur_long  = long_v;
    cur_short = short_v;
  endtask

  task automatic random_side_request();
    if ($urandom_range(0, 1) == 0) begin
      push_request(OP_CMD, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end else begin
      push_request(OP_READ, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    int len;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(60, 70);
          1, 2, 3: len = $urandom_range(1, (cur_short < 1) ? 1 : cur_short);
          4, 5, 6: len = cur_long + 2 - $urandom_range(0, 3);
          default: len = $urandom_range(1, 12);
        endcase
        if (len < 1) begin
          len = 1;
        end
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            random_side_request();
          end
          push_request(OP_TICK, 1'b1, 4'($urandom_range(0, 15)));
        end
        repeat ($urandom_range(1, 3)) begin
          push_request(OP_TICK, 1'b0, 4'($urandom_range(0, 15)));
        end
      end else if (pick < 75) begin
        push_request(OP_CMD, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else if (pick < 92) begin
        push_request(OP_READ, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else begin
        push_request(OP_NOP, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'd0;
    s_tuser     = OP_TICK;
    m_tready    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 4'd0;
    pwdata      = 32'd0;
    idle_cycles = 0;
    burst_left  = 0;
    items_sent  = 0;
    cur_long    = LONG_PRESS_RST;
    cur_short   = SHORT_LIMIT_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: divisor 0 wraps every tick
    set_registers(2, 3, 0);
    push_request(OP_READ, 1'b0, 4'd0);
    push_request(OP_NOP, 1'b1, 4'd15);
    push_request(OP_CMD, 1'b0, CMD_PWR_ON);
    push_request(OP_CMD, 1'b1, CMD_STA_ON);
    push_request(OP_CMD, 1'b0, CMD_PWR_OFF);
    push_request(OP_CMD, 1'b0, CMD_STA_OFF);
    push_request(OP_CMD, 1'b0, 4'd8);
    push_request(OP_CMD, 1'b0, 4'd15);
    push_request(OP_CMD, 1'b1, 4'($urandom_range(9, 14)));
    push_request(OP_CMD, 1'b0, CMD_STA_BLINK_ON);
    push_request(OP_CMD, 1'b0, CMD_PWR_BLINK_ON);
    repeat (3) push_request(OP_TICK, 1'b1, 4'd0);
    push_request(OP_TICK, 1'b0, 4'd15);
    push_request(OP_READ, 1'b0, 4'd0);
    push_request(OP_TICK, 1'b1, 4'd0);
    push_request(OP_TICK, 1'b0, 4'd0);
    // unread short press replaced by a long press
    repeat (3) push_request(OP_TICK, 1'b1, 4'd0);
    push_request(OP_TICK, 1'b0, 4'd0);
    push_request(OP_READ, 1'b1, 4'd0);
    push_request(OP_CMD, 1'b0, CMD_STA_BLINK_OFF);
    push_request(OP_CMD, 1'b0, CMD_PWR_BLINK_OFF);
    push_request(OP_TICK, 1'b0, 4'd0);

    set_registers(LONG_PRESS_RST, SHORT_LIMIT_RST, BLINK_DIV_RST);
    random_phase(90);
    set_registers(1, 63, 7);
    random_phase(90);
    set_registers(62, 1, 1);
    random_phase(90);
    set_registers(0, 0, 3);
    random_phase(90);
    set_registers(63, 20, 6);
    random_phase(90);
    set_registers($urandom_range(1, 62), $urandom_range(1, 63), $urandom_range(1, 7));
    random_phase(90);

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/bplb_pkg.sv
rtl/bplb_cfg.sv
rtl/button_press_classifier_led_blinker_core.sv
rtl/bplb_checker.sv
tb/led_event_checker.sv
tb/tb_top.sv
